### rtl/pbwd_pkg.sv
// Shared types and constants for the protobuf wire stream decoder.
// Used by the parser, the result queue and the top level.
package pbwd_pkg;

   // Bit width of the largest length that a length-delimited field may carry.
   localparam int LENGTH_BITS = 32;

   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = 2;
   localparam int RSP_CNT_W   = 3;

   localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

   localparam logic [2:0] WT_VARINT  = 3'd0;
   localparam logic [2:0] WT_FIXED64 = 3'd1;
   localparam logic [2:0] WT_LEN     = 3'd2;
   localparam logic [2:0] WT_FIXED32 = 3'd5;

   localparam logic [2:0] FLD_NONE   = 3'd0;
   localparam logic [2:0] FLD_STATUS = 3'd6;

   typedef enum logic [2:0] {
      PH_TAG,
      PH_VALUE,
      PH_LENGTH,
      PH_STRING,
      PH_SKIP
   } phase_type;

   typedef enum logic [2:0] {
      EV_VARINT,
      EV_STR_START,
      EV_STR_BYTE,
      EV_MSG_OK,
      EV_ERROR
   } evt_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_VARINT_LONG,
      ERR_WIRE_MISMATCH,
      ERR_BAD_WIRE,
      ERR_STATUS_RANGE,
      ERR_TRUNCATED
   } err_code_type;

   typedef struct packed {
      evt_kind_type kind;
      logic [2:0]   field_id;
      logic [63:0]  value;
      err_code_type err;
      logic         last;
   } evt_type;

   // Up to two events per input beat; vld1 is only set together with vld0.
   typedef struct packed {
      logic    vld0;
      logic    vld1;
      evt_type ev0;
      evt_type ev1;
   } evt_pair_type;

endpackage

### rtl/pbwd_intf.sv
// Valid/ready channel interfaces for the decoder's byte input and event output.
// No dependencies beyond the payload widths of the wire format.
interface pbwd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       message_end;

   modport source (output valid, data_byte, byte_present, message_end, input ready);
   modport sink   (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface pbwd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [2:0]  field_id;
   logic [63:0] field_value;
   logic [2:0]  error_code;
   logic        last_of_run;

   modport source (output valid, event_kind, field_id, field_value, error_code, last_of_run,
                   input ready);
   modport sink   (input valid, event_kind, field_id, field_value, error_code, last_of_run,
                   output ready);
endinterface

### rtl/protobuf_wire_stream_decoder.sv
// Protobuf wire format stream decoder, one message byte per request beat.
//
// req_if carries data_byte, byte_present and message_end; a beat with
// byte_present low and message_end high closes a message without a byte.
// rsp_if carries events: varint field values (fields 1, 2, 6), string start
// and string bytes (fields 3, 4, 5, 7), message ok, and errors. Each request
// beat yields zero, one or two events; last_of_run marks the final one.
//
// Events are registered in the queue before being offered on rsp_if. One byte
// is taken per cycle while the queue has room. The parser updates all state in
// the cycle the byte is taken, and events go into a four-entry queue that
// drains one per cycle while rsp_if.ready is high.
// req_if.ready is high while the queue has two free entries; it does not look
// at rsp_if.ready, so a stalled receiver stops input before the queue fills.
// Reset clears parse state and empties the queue; no events are offered.
// After an error, bytes are dropped silently until the message end.
module protobuf_wire_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   pbwd_req_if.sink   req_if,
   pbwd_rsp_if.source rsp_if
);

   pbwd_pkg::evt_pair_type evts;
   pbwd_pkg::evt_type      head;
   logic                   take;
   logic                   room;

   assign take          = req_if.valid && req_if.ready;
   assign req_if.ready  = room;

   pbwd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .data_byte    (req_if.data_byte),
      .byte_present (req_if.byte_present),
      .message_end  (req_if.message_end),
      .evts         (evts)
   );

   pbwd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .evts      (evts),
      .room      (room),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_evt   (head)
   );

   assign rsp_if.event_kind  = head.kind;
   assign rsp_if.field_id    = head.field_id;
   assign rsp_if.field_value = head.value;
   assign rsp_if.error_code  = head.err;
   assign rsp_if.last_of_run = head.last;

endmodule

### rtl/pbwd_parser.sv
// Wire format parse state and per-beat event generation.
// Depends on pbwd_pkg for the phase, event and error types.
module pbwd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            data_byte,
   input  logic                  byte_present,
   input  logic                  message_end,
   output pbwd_pkg::evt_pair_type evts
);

   localparam int LB = pbwd_pkg::LENGTH_BITS;

   pbwd_pkg::phase_type phase_ff, phase_in, phase_mid;
   logic [63:0]         acc_ff, acc_in, acc_mid;
   logic [3:0]          cnt_ff, cnt_in, cnt_mid;
   logic [2:0]          field_ff, field_in, field_mid;
   logic [LB-1:0]       rem_ff, rem_in, rem_mid;
   logic                err_ff, err_in, err_mid;

   logic                byte_fire, end_fire, in_data, cont, too_long;
   logic [6:0]          shamt;
   logic [63:0]         acc_new;
   logic [3:0]          cnt_inc;
   logic [LB-1:0]       rem_dec;
   logic                status_range, len_over;
   logic [2:0]          tag_fid, tag_wt;
   logic                tag_err;
   pbwd_pkg::err_code_type tag_code;
   pbwd_pkg::phase_type tag_phase;
   logic [LB-1:0]       tag_rem;
   logic                bev_vld, eev_vld;
   pbwd_pkg::evt_type   bev, eev;

   assign byte_fire    = take && byte_present && !err_ff;
   assign end_fire     = take && message_end;
   assign in_data      = (phase_ff == pbwd_pkg::PH_STRING) || (phase_ff == pbwd_pkg::PH_SKIP);
   assign cont         = data_byte[7];
   assign shamt        = 7'({cnt_ff, 3'b000}) - 7'(cnt_ff);
   assign acc_new      = acc_ff | (64'(data_byte[6:0]) << shamt);
   assign cnt_inc      = cnt_ff + 4'd1;
   assign too_long     = cont && (cnt_inc >= pbwd_pkg::VARINT_MAX_BYTES);
   assign rem_dec      = rem_ff - LB'(1);
   assign status_range = (field_ff == pbwd_pkg::FLD_STATUS) && (acc_new[63:31] != '0);
   assign len_over     = (acc_new >> LB) != 64'd0;

   // Tag decode: field number 1..7 only when the whole number is small.
   assign tag_fid = (acc_new[63:6] == '0) ? acc_new[5:3] : pbwd_pkg::FLD_NONE;
   assign tag_wt  = acc_new[2:0];

   always_comb begin
      tag_err   = 1'b0;
      tag_code  = pbwd_pkg::ERR_NONE;
      tag_phase = pbwd_pkg::PH_TAG;
      tag_rem   = rem_ff;
      if (tag_fid inside {3'd1, 3'd2, pbwd_pkg::FLD_STATUS}) begin
         if (tag_wt == pbwd_pkg::WT_VARINT) begin
            tag_phase = pbwd_pkg::PH_VALUE;
         end else begin
            tag_err  = 1'b1;
            tag_code = pbwd_pkg::ERR_WIRE_MISMATCH;
         end
      end else if (tag_fid != pbwd_pkg::FLD_NONE) begin
         if (tag_wt == pbwd_pkg::WT_LEN) begin
            tag_phase = pbwd_pkg::PH_LENGTH;
         end else begin
            tag_err  = 1'b1;
            tag_code = pbwd_pkg::ERR_WIRE_MISMATCH;
         end
      end else begin
         case (tag_wt)
            pbwd_pkg::WT_VARINT: begin
               tag_phase = pbwd_pkg::PH_VALUE;
            end
            pbwd_pkg::WT_FIXED64: begin
               tag_phase = pbwd_pkg::PH_SKIP;
               tag_rem   = LB'(8);
            end
            pbwd_pkg::WT_LEN: begin
               tag_phase = pbwd_pkg::PH_LENGTH;
            end
            pbwd_pkg::WT_FIXED32: begin
               tag_phase = pbwd_pkg::PH_SKIP;
               tag_rem   = LB'(4);
            end
            default: begin
               tag_err  = 1'b1;
               tag_code = pbwd_pkg::ERR_BAD_WIRE;
            end
         endcase
      end
   end

   // Next state: first the effect of the byte, then the message end.
   always_comb begin
      phase_mid = phase_ff;
      acc_mid   = acc_ff;
      cnt_mid   = cnt_ff;
      field_mid = field_ff;
      rem_mid   = rem_ff;
      err_mid   = err_ff;
      if (byte_fire) begin
         if (in_data) begin
            rem_mid = rem_dec;
            if (rem_dec == '0) begin
               phase_mid = pbwd_pkg::PH_TAG;
            end
         end else if (cont) begin
            acc_mid = acc_new;
            cnt_mid = cnt_inc;
            err_mid = too_long;
         end else begin
            acc_mid = '0;
            cnt_mid = '0;
            case (phase_ff)
               pbwd_pkg::PH_TAG: begin
                  field_mid = tag_fid;
                  if (tag_err) begin
                     err_mid = 1'b1;
                  end else begin
                     phase_mid = tag_phase;
                     rem_mid   = tag_rem;
                  end
               end
               pbwd_pkg::PH_VALUE: begin
                  if (status_range) begin
                     err_mid = 1'b1;
                  end else begin
                     phase_mid = pbwd_pkg::PH_TAG;
                  end
               end
               pbwd_pkg::PH_LENGTH: begin
                  if (len_over) begin
                     err_mid = 1'b1;
                  end else begin
                     rem_mid = acc_new[LB-1:0];
                     if (acc_new == 64'd0) begin
                        phase_mid = pbwd_pkg::PH_TAG;
                     end else if (field_ff != pbwd_pkg::FLD_NONE) begin
                        phase_mid = pbwd_pkg::PH_STRING;
                     end else begin
                        phase_mid = pbwd_pkg::PH_SKIP;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (end_fire) begin
         phase_in = pbwd_pkg::PH_TAG;
         acc_in   = '0;
         cnt_in   = '0;
         field_in = pbwd_pkg::FLD_NONE;
         rem_in   = '0;
         err_in   = 1'b0;
      end else begin
         phase_in = phase_mid;
         acc_in   = acc_mid;
         cnt_in   = cnt_mid;
         field_in = field_mid;
         rem_in   = rem_mid;
         err_in   = err_mid;
      end
   end

   // Events: the byte's event, then the end-of-message report.
   always_comb begin
      bev_vld = 1'b0;
      bev     = '0;
      if (byte_fire) begin
         if (in_data) begin
            if (phase_ff == pbwd_pkg::PH_STRING) begin
               bev_vld      = 1'b1;
               bev.kind     = pbwd_pkg::EV_STR_BYTE;
               bev.field_id = field_ff;
               bev.value    = 64'(data_byte);
            end
         end else if (cont) begin
            if (too_long) begin
               bev_vld      = 1'b1;
               bev.kind     = pbwd_pkg::EV_ERROR;
               bev.field_id = (phase_ff == pbwd_pkg::PH_TAG) ? pbwd_pkg::FLD_NONE : field_ff;
               bev.err      = pbwd_pkg::ERR_VARINT_LONG;
            end
         end else begin
            case (phase_ff)
               pbwd_pkg::PH_TAG: begin
                  if (tag_err) begin
                     bev_vld      = 1'b1;
                     bev.kind     = pbwd_pkg::EV_ERROR;
                     bev.field_id = tag_fid;
                     bev.err      = tag_code;
                  end
               end
               pbwd_pkg::PH_VALUE: begin
                  if (status_range) begin
                     bev_vld      = 1'b1;
                     bev.kind     = pbwd_pkg::EV_ERROR;
                     bev.field_id = field_ff;
                     bev.err      = pbwd_pkg::ERR_STATUS_RANGE;
                  end else if (field_ff != pbwd_pkg::FLD_NONE) begin
                     bev_vld      = 1'b1;
                     bev.kind     = pbwd_pkg::EV_VARINT;
                     bev.field_id = field_ff;
                     bev.value    = acc_new;
                  end
               end
               pbwd_pkg::PH_LENGTH: begin
                  if (len_over) begin
                     bev_vld      = 1'b1;
                     bev.kind     = pbwd_pkg::EV_ERROR;
                     bev.field_id = field_ff;
                     bev.err      = pbwd_pkg::ERR_TRUNCATED;
                  end else if (field_ff != pbwd_pkg::FLD_NONE) begin
                     bev_vld      = 1'b1;
                     bev.kind     = pbwd_pkg::EV_STR_START;
                     bev.field_id = field_ff;
                     bev.value    = acc_new;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      // An error raised before or by this beat suppresses the end report.
      eev_vld = end_fire && !err_mid;
      eev     = '0;
      if ((phase_mid == pbwd_pkg::PH_TAG) && (cnt_mid == '0)) begin
         eev.kind = pbwd_pkg::EV_MSG_OK;
      end else begin
         eev.kind     = pbwd_pkg::EV_ERROR;
         eev.field_id = (phase_mid == pbwd_pkg::PH_TAG) ? pbwd_pkg::FLD_NONE : field_mid;
         eev.err      = pbwd_pkg::ERR_TRUNCATED;
      end
      eev.last = 1'b1;
      bev.last = !eev_vld;

      evts.vld0 = bev_vld || eev_vld;
      evts.vld1 = bev_vld && eev_vld;
      evts.ev0  = bev_vld ? bev : eev;
      evts.ev1  = eev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pbwd_pkg::PH_TAG;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         field_ff <= pbwd_pkg::FLD_NONE;
         rem_ff   <= '0;
         err_ff   <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         field_ff <= field_in;
         rem_ff   <= rem_in;
         err_ff   <= err_in;
      end
   end

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      evts.vld1 |-> evts.vld0 && !evts.ev0.last && evts.ev1.last)
      else $error("second event without a first, or last flag misplaced");

   a_quiet_after_error: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> !evts.vld0)
      else $error("event produced while an error is latched");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      end_fire |=> (phase_ff == pbwd_pkg::PH_TAG) && (cnt_ff == '0) && !err_ff)
      else $error("parse state not cleared after message end");

   a_varint_bound: assert property (@(posedge clock) disable iff (reset)
      !err_ff |-> cnt_ff < pbwd_pkg::VARINT_MAX_BYTES)
      else $error("varint byte count past limit without an error");

endmodule

### rtl/pbwd_rsp_queue.sv
// Small result queue: takes up to two events a cycle, delivers one per beat.
// Depends on pbwd_pkg for the event types and queue sizing.
module pbwd_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  pbwd_pkg::evt_pair_type evts,
   output logic                   room,
   output logic                   out_valid,
   input  logic                   out_ready,
   output pbwd_pkg::evt_type      out_evt
);

   pbwd_pkg::evt_type mem [pbwd_pkg::RSP_DEPTH];

   logic [pbwd_pkg::RSP_PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in, wptr_nxt;
   logic [pbwd_pkg::RSP_CNT_W-1:0] cnt_ff, cnt_in, push_n;
   logic                           pop;

   assign push_n    = pbwd_pkg::RSP_CNT_W'(evts.vld0) + pbwd_pkg::RSP_CNT_W'(evts.vld1);
   assign out_valid = cnt_ff != '0;
   assign pop       = out_valid && out_ready;
   assign out_evt   = mem[rptr_ff];
   // Accept a beat only with room for both of its possible events.
   assign room      = cnt_ff <= pbwd_pkg::RSP_CNT_W'(pbwd_pkg::RSP_DEPTH - 2);
   assign wptr_nxt  = wptr_ff + pbwd_pkg::RSP_PTR_W'(1);
   assign wptr_in   = wptr_ff + push_n[pbwd_pkg::RSP_PTR_W-1:0];
   assign rptr_in   = rptr_ff + pbwd_pkg::RSP_PTR_W'(pop);
   assign cnt_in    = cnt_ff + push_n - pbwd_pkg::RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (evts.vld0) begin
         mem[wptr_ff] <= evts.ev0;
      end
      if (evts.vld1) begin
         mem[wptr_nxt] <= evts.ev1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= pbwd_pkg::RSP_CNT_W'(pbwd_pkg::RSP_DEPTH))
      else $error("result queue overflow");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      evts.vld0 |-> room)
      else $error("events pushed without room");

   a_drain_step: assert property (@(posedge clock) disable iff (reset)
      (pop && !evts.vld0) |=> cnt_ff == $past(cnt_ff) - pbwd_pkg::RSP_CNT_W'(1))
      else $error("queue count did not drop after a lone pop");

endmodule

### test/testbench.sv
// Self-checking bench for protobuf_wire_stream_decoder: byte beats in, wire events out.
// Depends on pbwd_pkg and the pbwd_req_if / pbwd_rsp_if channel interfaces.
`timescale 1ns / 1ps

typedef struct packed {
   logic [7:0] data;
   logic       present;
   logic       fin;
} byte_beat_type;

class wire_event_scoreboard_type;
   pbwd_pkg::phase_type phase;
   logic [63:0]         acc;
   logic [3:0]          nbytes;
   logic [2:0]          fld;
   logic [63:0]         remaining;
   bit                  halted;
   pbwd_pkg::evt_type   expected_events[$];
   int                  errors;
   int                  seen;

   function new();
      clear();
      errors = 0;
      seen   = 0;
   endfunction

   function void clear();
      phase     = pbwd_pkg::PH_TAG;
      acc       = 64'd0;
      nbytes    = 4'd0;
      fld       = pbwd_pkg::FLD_NONE;
      remaining = 64'd0;
      halted    = 1'b0;
   endfunction

   function int pending();
      return expected_events.size();
   endfunction

   function void append_event(pbwd_pkg::evt_type e);
      expected_events.insert(expected_events.size(), e);
   endfunction

   function void emit(pbwd_pkg::evt_kind_type k, logic [2:0] fid, logic [63:0] val,
                      pbwd_pkg::err_code_type c);
      pbwd_pkg::evt_type e;
      e = '{kind: k, field_id: fid, value: val, err: c, last: 1'b0};
      append_event(e);
   endfunction

   function void fail(logic [2:0] fid, pbwd_pkg::err_code_type c);
      emit(pbwd_pkg::EV_ERROR, fid, 64'd0, c);
      halted = 1'b1;
   endfunction

   function void decode_tag(logic [63:0] tag);
      logic [63:0] num;
      logic [2:0]  wt;
      logic [2:0]  fid;
      num = tag >> 3;
      wt  = tag[2:0];
      fid = (num >= 64'd1 && num <= 64'd7) ? num[2:0] : pbwd_pkg::FLD_NONE;
      fld = fid;
      case (fid)
         3'd1, 3'd2, pbwd_pkg::FLD_STATUS: begin
            if (wt != pbwd_pkg::WT_VARINT) fail(fid, pbwd_pkg::ERR_WIRE_MISMATCH);
            else phase = pbwd_pkg::PH_VALUE;
         end
         pbwd_pkg::FLD_NONE: begin
            case (wt)
               pbwd_pkg::WT_VARINT:  phase = pbwd_pkg::PH_VALUE;
               pbwd_pkg::WT_FIXED64: begin
                  remaining = 64'd8;
                  phase     = pbwd_pkg::PH_SKIP;
               end
               pbwd_pkg::WT_LEN:     phase = pbwd_pkg::PH_LENGTH;
               pbwd_pkg::WT_FIXED32: begin
                  remaining = 64'd4;
                  phase     = pbwd_pkg::PH_SKIP;
               end
               default:    fail(pbwd_pkg::FLD_NONE, pbwd_pkg::ERR_BAD_WIRE);
            endcase
         end
         default: begin
            if (wt != pbwd_pkg::WT_LEN) fail(fid, pbwd_pkg::ERR_WIRE_MISMATCH);
            else phase = pbwd_pkg::PH_LENGTH;
         end
      endcase
   endfunction

   function void decode_byte(logic [7:0] b);
      logic [63:0] v;
      if (phase == pbwd_pkg::PH_STRING || phase == pbwd_pkg::PH_SKIP) begin
         if (phase == pbwd_pkg::PH_STRING)
            emit(pbwd_pkg::EV_STR_BYTE, fld, {56'd0, b}, pbwd_pkg::ERR_NONE);
         remaining = remaining - 64'd1;
         if (remaining == 64'd0) phase = pbwd_pkg::PH_TAG;
         return;
      end
      // bits shifted past bit 63 on the tenth byte drop out here
      acc    = acc | ({57'd0, b[6:0]} << (7 * nbytes));
      nbytes = nbytes + 4'd1;
      if (b[7]) begin
         if (nbytes >= pbwd_pkg::VARINT_MAX_BYTES)
            fail((phase == pbwd_pkg::PH_TAG) ? pbwd_pkg::FLD_NONE : fld,
                 pbwd_pkg::ERR_VARINT_LONG);
         return;
      end
      v      = acc;
      acc    = 64'd0;
      nbytes = 4'd0;
      case (phase)
         pbwd_pkg::PH_TAG: decode_tag(v);
         pbwd_pkg::PH_VALUE: begin
            if (fld == pbwd_pkg::FLD_STATUS && v > 64'h7fff_ffff) begin
               fail(fld, pbwd_pkg::ERR_STATUS_RANGE);
               return;
            end
            if (fld != pbwd_pkg::FLD_NONE)
               emit(pbwd_pkg::EV_VARINT, fld, v, pbwd_pkg::ERR_NONE);
            phase = pbwd_pkg::PH_TAG;
         end
         default: begin
            if ((v >> pbwd_pkg::LENGTH_BITS) != 64'd0) begin
               fail(fld, pbwd_pkg::ERR_TRUNCATED);
               return;
            end
            remaining = v;
            if (fld != pbwd_pkg::FLD_NONE)
               emit(pbwd_pkg::EV_STR_START, fld, v, pbwd_pkg::ERR_NONE);
            if (v == 64'd0) phase = pbwd_pkg::PH_TAG;
            else phase = (fld != pbwd_pkg::FLD_NONE) ? pbwd_pkg::PH_STRING : pbwd_pkg::PH_SKIP;
         end
      endcase
   endfunction

   function void note_beat(byte_beat_type bt);
      int                first;
      bit                was_halted;
      pbwd_pkg::evt_type e;
      first      = expected_events.size();
      was_halted = halted;
      if (bt.present && !halted) decode_byte(bt.data);
      if (bt.fin) begin
         if (!was_halted && !halted) begin
            if (phase == pbwd_pkg::PH_TAG && nbytes == 4'd0)
               emit(pbwd_pkg::EV_MSG_OK, pbwd_pkg::FLD_NONE, 64'd0, pbwd_pkg::ERR_NONE);
            else
               emit(pbwd_pkg::EV_ERROR,
                    (phase == pbwd_pkg::PH_TAG) ? pbwd_pkg::FLD_NONE : fld,
                    64'd0, pbwd_pkg::ERR_TRUNCATED);
         end
         clear();
      end
      if (expected_events.size() > first) begin
         e      = expected_events.pop_back();
         e.last = 1'b1;
         append_event(e);
      end
   endfunction

   task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   task check_event(logic [2:0] k, logic [2:0] f, logic [63:0] v, logic [2:0] c, logic l);
      pbwd_pkg::evt_type want;
      seen++;
      if (expected_events.size() == 0) begin
         report($sformatf("event %0d (kind %0d field %0d) with none expected", seen, k, f));
         return;
      end
      want = expected_events.pop_front();
      if (k !== want.kind)
         report($sformatf("event %0d kind %0d, expected %0d", seen, k, want.kind));
      if (f !== want.field_id)
         report($sformatf("event %0d field_id %0d, expected %0d", seen, f, want.field_id));
      if (v !== want.value)
         report($sformatf("event %0d field_value %0h, expected %0h", seen, v, want.value));
      if (c !== want.err)
         report($sformatf("event %0d error_code %0d, expected %0d", seen, c, want.err));
      if (l !== want.last)
         report($sformatf("event %0d last_of_run %0d, expected %0d", seen, l, want.last));
   endtask
endclass

module testbench;
   localparam int QUIET_LIMIT = 2000;
   localparam int ITEM_TARGET = 1900;

   logic clock;
   logic reset;
   bit   armed;
   bit   req_burst;
   bit   rsp_burst;
   int   items_sent;
   int   next_pause;

   byte_beat_type             plan_q[$];
   wire_event_scoreboard_type sb;

   pbwd_req_if req_if();
   pbwd_rsp_if rsp_if();

   protobuf_wire_stream_decoder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [63:0] rand_bits(int n);
      logic [63:0] v;
      v = {$urandom, $urandom};
      if (n < 64) v = v & ((64'd1 << n) - 64'd1);
      return v;
   endfunction

   function automatic void plan_append(byte_beat_type bt);
      plan_q.insert(plan_q.size(), bt);
   endfunction

   function automatic void add_byte(logic [7:0] b);
      plan_append('{data: b, present: 1'b1, fin: 1'b0});
   endfunction

   function automatic void add_end_only();
      plan_append('{data: 8'($urandom), present: 1'b0, fin: 1'b1});
   endfunction

   function automatic void mark_end();
      byte_beat_type bt;
      if (plan_q.size() == 0) begin
         add_end_only();
         return;
      end
      bt     = plan_q.pop_back();
      bt.fin = 1'b1;
      plan_append(bt);
   endfunction

   function automatic void add_varint(logic [63:0] v);
      logic [7:0] b;
      do begin
         b = {1'b0, v[6:0]};
         v = v >> 7;
         if (v != 64'd0) b[7] = 1'b1;
         add_byte(b);
      end while (v != 64'd0);
   endfunction

   function automatic void add_tag(logic [63:0] num, logic [2:0] wt);
      add_varint({num[60:0], wt});
   endfunction

   function automatic logic [63:0] unknown_field();
      case ($urandom_range(0, 2))
         0:       return 64'd0;
         1:       return 64'($urandom_range(8, 40));
         default: return {$urandom, $urandom} >> 3;
      endcase
   endfunction

   // One message: mostly well-formed fields, some broken ones, sometimes cut short.
   function automatic void gen_message();
      int          pick;
      int          len;
      logic [63:0] num;
      logic [2:0]  wt;
      logic [2:0]  legal_wt;
      repeat ($urandom_range(0, 5)) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            case ($urandom_range(0, 2))
               0:       num = 64'd1;
               1:       num = 64'd2;
               default: num = 64'(pbwd_pkg::FLD_STATUS);
            endcase
            add_tag(num, pbwd_pkg::WT_VARINT);
            if (num == 64'(pbwd_pkg::FLD_STATUS) && $urandom_range(0, 3) != 0)
               add_varint(rand_bits($urandom_range(0, 31)));
            else
               add_varint(rand_bits($urandom_range(0, 64)));
         end else if (pick < 50) begin
            case ($urandom_range(0, 3))
               0:       num = 64'd3;
               1:       num = 64'd4;
               2:       num = 64'd5;
               default: num = 64'd7;
            endcase
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
            add_tag(num, pbwd_pkg::WT_LEN);
            add_varint(64'(len));
            repeat (len) add_byte(8'($urandom));
         end else if (pick < 75) begin
            num = unknown_field();
            case ($urandom_range(0, 3))
               0: begin
                  add_tag(num, pbwd_pkg::WT_VARINT);
                  add_varint(rand_bits($urandom_range(0, 64)));
               end
               1: begin
                  add_tag(num, pbwd_pkg::WT_FIXED64);
                  repeat (8) add_byte(8'($urandom));
               end
               2: begin
                  len = $urandom_range(0, 8);
                  add_tag(num, pbwd_pkg::WT_LEN);
                  add_varint(64'(len));
                  repeat (len) add_byte(8'($urandom));
               end
               default: begin
                  add_tag(num, pbwd_pkg::WT_FIXED32);
                  repeat (4) add_byte(8'($urandom));
               end
            endcase
         end else begin
            case ($urandom_range(0, 5))
               0: begin
                  num      = 64'($urandom_range(1, 7));
                  legal_wt = (num == 64'd1 || num == 64'd2 ||
                              num == 64'(pbwd_pkg::FLD_STATUS)) ?
                             pbwd_pkg::WT_VARINT : pbwd_pkg::WT_LEN;
                  do wt = 3'($urandom); while (wt == legal_wt);
                  add_tag(num, wt);
               end
               1: begin
                  do wt = 3'($urandom);
                  while (wt == pbwd_pkg::WT_VARINT || wt == pbwd_pkg::WT_FIXED64 ||
                         wt == pbwd_pkg::WT_LEN || wt == pbwd_pkg::WT_FIXED32);
                  add_tag(unknown_field(), wt);
               end
               2: begin
                  num = ($urandom_range(0, 1) == 0) ? 64'd4 : unknown_field();
                  add_tag(num, pbwd_pkg::WT_LEN);
                  if ($urandom_range(0, 3) == 0) add_varint(64'h1_0000_0000);
                  else add_varint({$urandom_range(1, 32'hffff_ffff), $urandom});
               end
               3: begin
                  if ($urandom_range(0, 1) == 0) add_tag(64'd1, pbwd_pkg::WT_VARINT);
                  repeat (10) add_byte({1'b1, 7'($urandom)});
               end
               4: begin
                  add_tag(64'd2, pbwd_pkg::WT_VARINT);
                  repeat (9) add_byte({1'b1, 7'($urandom)});
                  add_byte({1'b0, 7'($urandom)});
               end
               default: repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
            endcase
         end
      end
      if ($urandom_range(0, 3) == 0 && plan_q.size() > 0) begin
         len = $urandom_range(1, plan_q.size());
         repeat (len) void'(plan_q.pop_back());
      end
      if ($urandom_range(0, 1) == 0) mark_end();
      else add_end_only();
   endfunction

   task automatic send_beat(byte_beat_type bt);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.data_byte    <= bt.data;
      req_if.byte_present <= bt.present;
      req_if.message_end  <= bt.fin;
      do @(posedge clock); while (!req_if.ready);
      sb.note_beat(bt);
      if (bt.present || bt.fin) items_sent++;
   endtask

   task automatic play_plan();
      byte_beat_type bt;
      while (plan_q.size() > 0) begin
         // slip in a beat with neither byte nor end now and then
         if ($urandom_range(0, 29) == 0)
            send_beat('{data: 8'($urandom), present: 1'b0, fin: 1'b0});
         bt = plan_q.pop_front();
         send_beat(bt);
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // response side: random stall per event, with stretches of none
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      while (!armed) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         sb.check_event(rsp_if.event_kind, rsp_if.field_id, rsp_if.field_value,
                        rsp_if.error_code, rsp_if.last_of_run);
      end
   end

   // watchdog: end the run after too many cycles without any beat
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("testbench: errors");
      $finish;
   end

   initial begin
      sb                  = new();
      items_sent          = 0;
      next_pause          = 500;
      req_burst           = 1'b0;
      rsp_burst           = 1'b0;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.data_byte    <= 8'd0;
      req_if.byte_present <= 1'b0;
      req_if.message_end  <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      armed = 1'b1;

      plan_append('{data: 8'h5a, present: 1'b0, fin: 1'b0});
      add_end_only();
      add_byte(8'h08); add_byte(8'hff); add_byte(8'h01); mark_end();
      add_byte(8'h1a); add_byte(8'h00); mark_end();
      add_byte(8'h22); add_byte(8'h01); add_byte(8'h00); mark_end();
      add_byte(8'h09); mark_end();
      add_byte(8'h43); mark_end();
      add_tag(64'(pbwd_pkg::FLD_STATUS), pbwd_pkg::WT_VARINT); add_varint(64'h8000_0000);
      mark_end();
      add_byte(8'h08); add_end_only();
      add_tag(64'd3, pbwd_pkg::WT_LEN); add_varint(64'h1_0000_0000); mark_end();
      repeat (10) add_byte(8'hff);
      add_byte(8'h2c); add_end_only();
      add_tag(64'd2, pbwd_pkg::WT_VARINT);
      repeat (9) add_byte(8'hff);
      add_byte(8'h7f); mark_end();
      play_plan();
      drain();

      while (items_sent < ITEM_TARGET) begin
         req_burst = ($urandom_range(0, 4) == 0);
         gen_message();
         play_plan();
         if (items_sent >= next_pause) begin
            drain();
            next_pause += 500;
         end
      end
      drain();
      repeat (20) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end
endmodule
